// File: sv/cbe_pkg.sv
// ----------------------------------------------------------------------------
// cbe_pkg
// Shared types, widths and sample-weight functions for the easing evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package cbe_pkg;

  // Curve sampling: SAMPLE_POINTS parameters u_i = i / SAMPLE_POINTS (power of two)
  localparam int SAMPLE_POINTS = 64;
  localparam int IDX_W         = $clog2(SAMPLE_POINTS);
  localparam int SEARCH_STEPS  = $clog2(SAMPLE_POINTS - 1);
  localparam int N3_SHIFT      = 3 * IDX_W;

  // Sample arithmetic widths
  localparam int K_W   = N3_SHIFT;
  localparam int K3_W  = N3_SHIFT + 16;
  localparam int P_W   = K_W + 16;
  localparam int SUM_W = N3_SHIFT + 18;
  localparam int X_W   = SUM_W - N3_SHIFT;

  // Parameter u in Q.16 and the interpolation divider
  localparam int U_W        = 17;
  localparam int U_ONE      = 65536;
  localparam int FRAC_SHIFT = 16 - IDX_W;
  localparam int R_W        = 16 + FRAC_SHIFT;
  localparam int Q_W        = 18;
  localparam int DIV_BITS   = 2;
  localparam int DIV_STEPS  = Q_W / DIV_BITS;
  localparam int D_W        = X_W + 1;

  // Output format
  localparam int EASED_W   = 15;
  localparam int EASED_MAX = 16383;
  localparam int EASED_MIN = -16384;
  localparam int S_W       = 66;
  localparam int YF_W      = S_W - 48;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CTRL1_X = 2'd0,
    REG_CTRL1_Y = 2'd1,
    REG_CTRL2_X = 2'd2,
    REG_CTRL2_Y = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic        [15:0] c1x;
    logic signed [14:0] c1y;
    logic        [15:0] c2x;
    logic signed [14:0] c2y;
  } cfg_t;

  // Search window carried between search steps
  typedef struct packed {
    logic [IDX_W-1:0] l;
    logic [IDX_W-1:0] r;
    logic [15:0]      prog;
  } srch_t;

  // Divider state carried between divider steps
  typedef struct packed {
    logic [IDX_W-1:0] left;
    logic             pos;
    logic             ovf;
    logic [X_W-1:0]   d;
    logic [D_W-1:0]   rem;
    logic [Q_W-1:0]   low;
    logic [Q_W-1:0]   q;
  } div_t;

  // Weight of ctrl1_x in sample i: 3*i*(N-i)^2
  function automatic logic [K_W-1:0] coef1(input logic [IDX_W-1:0] i);
    longint a;
    longint b;
    a = longint'(i);
    b = longint'(SAMPLE_POINTS) - a;
    return K_W'(3 * a * b * b);
  endfunction

  // Weight of ctrl2_x in sample i: 3*i^2*(N-i)
  function automatic logic [K_W-1:0] coef2(input logic [IDX_W-1:0] i);
    longint a;
    longint b;
    a = longint'(i);
    b = longint'(SAMPLE_POINTS) - a;
    return K_W'(3 * a * a * b);
  endfunction

  // End point term plus rounding half: i^3*32768 + N^3/2
  function automatic logic [K3_W-1:0] coef3(input logic [IDX_W-1:0] i);
    longint a;
    a = longint'(i);
    return K3_W'(a * a * a * 32768 + (longint'(1) <<< (N3_SHIFT - 1)));
  endfunction

endpackage

`default_nettype wire

// File: sv/cbe_search_step.sv
// ----------------------------------------------------------------------------
// cbe_search_step
// One binary-search step over the sampled curve x values, two stages deep.
// ----------------------------------------------------------------------------
`default_nettype none

module cbe_search_step (
  input  wire               clk,
  input  wire               rst,
  input  wire               en,
  input  cbe_pkg::cfg_t     cfg,
  input  wire               in_valid,
  input  cbe_pkg::srch_t    in_srch,
  output logic              out_valid,
  output cbe_pkg::srch_t    out_srch
);

  logic [cbe_pkg::IDX_W:0]      mid_sum;
  logic [cbe_pkg::IDX_W-1:0]    mid;

  logic                         a_valid;
  cbe_pkg::srch_t               a_srch;
  logic                         a_active;
  logic [cbe_pkg::IDX_W-1:0]    a_mid;
  logic [cbe_pkg::P_W-1:0]      a_p1;
  logic [cbe_pkg::P_W-1:0]      a_p2;
  logic [cbe_pkg::K3_W-1:0]     a_k3;

  logic [cbe_pkg::SUM_W-1:0]    x_sum;
  logic [cbe_pkg::X_W-1:0]      x_mid;
  cbe_pkg::srch_t               b_srch;

  // Pick the midpoint and weigh its sample
  assign mid_sum = {1'b0, in_srch.l} + {1'b0, in_srch.r} + 1'b1;
  assign mid     = mid_sum[cbe_pkg::IDX_W:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_srch   <= in_srch;
      a_active <= (in_srch.r - in_srch.l) > cbe_pkg::IDX_W'(1);
      a_mid    <= mid;
      a_p1     <= cbe_pkg::P_W'(cbe_pkg::coef1(mid)) * cbe_pkg::P_W'(cfg.c1x);
      a_p2     <= cbe_pkg::P_W'(cbe_pkg::coef2(mid)) * cbe_pkg::P_W'(cfg.c2x);
      a_k3     <= cbe_pkg::coef3(mid);
    end
  end

  // Form the sample and narrow the window
  assign x_sum = cbe_pkg::SUM_W'(a_p1) + cbe_pkg::SUM_W'(a_p2) + cbe_pkg::SUM_W'(a_k3);
  assign x_mid = x_sum[cbe_pkg::SUM_W-1:cbe_pkg::N3_SHIFT];

  always_comb begin
    b_srch = a_srch;
    if (a_active) begin
      if (cbe_pkg::X_W'(a_srch.prog) < x_mid) begin
        b_srch.r = a_mid;
      end else begin
        b_srch.l = a_mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_srch <= b_srch;
    end
  end

endmodule

`default_nettype wire

// File: sv/cbe_div_step.sv
// ----------------------------------------------------------------------------
// cbe_div_step
// One restoring-division stage that retires DIV_BITS quotient bits.
// ----------------------------------------------------------------------------
`default_nettype none

module cbe_div_step (
  input  wire             clk,
  input  wire             rst,
  input  wire             en,
  input  wire             in_valid,
  input  cbe_pkg::div_t   in_div,
  output logic            out_valid,
  output cbe_pkg::div_t   out_div
);

  cbe_pkg::div_t          nxt;
  logic [cbe_pkg::D_W-1:0] trial;

  // Shift in dividend bits and subtract where the divisor fits
  always_comb begin
    nxt   = in_div;
    trial = '0;
    for (int k = 0; k < cbe_pkg::DIV_BITS; k++) begin
      trial   = {nxt.rem[cbe_pkg::D_W-2:0], nxt.low[cbe_pkg::Q_W-1]};
      nxt.low = {nxt.low[cbe_pkg::Q_W-2:0], 1'b0};
      if (trial >= cbe_pkg::D_W'(nxt.d)) begin
        nxt.rem = trial - cbe_pkg::D_W'(nxt.d);
        nxt.q   = {nxt.q[cbe_pkg::Q_W-2:0], 1'b1};
      end else begin
        nxt.rem = trial;
        nxt.q   = {nxt.q[cbe_pkg::Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_div <= nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/cbe_cubic.sv
// ----------------------------------------------------------------------------
// cbe_cubic
// Evaluates y(u) of the cubic curve in six stages, rounds and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module cbe_cubic (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  en,
  input  cbe_pkg::cfg_t                        cfg,
  input  wire                                  in_valid,
  input  wire [cbe_pkg::U_W-1:0]               in_u,
  input  wire                                  in_sat,
  output logic                                 out_valid,
  output logic signed [cbe_pkg::EASED_W-1:0]   out_eased,
  output logic                                 out_sat
);

  logic [cbe_pkg::U_W-1:0]     v;

  logic [4:0]                  vld;
  logic [4:0]                  sat;

  logic [cbe_pkg::U_W-1:0]     c1_u;
  logic [33:0]                 c1_uv;
  logic [33:0]                 c1_uu;
  logic signed [32:0]          c1_vc;
  logic signed [32:0]          c1_uc;

  logic [cbe_pkg::U_W-1:0]     c2_u;
  logic [33:0]                 c2_uv;
  logic [33:0]                 c2_uu;
  logic signed [33:0]          c2_w;

  logic [49:0]                 c3_plo;
  logic signed [52:0]          c3_phi;
  logic [50:0]                 c3_u3;

  logic signed [cbe_pkg::S_W-1:0] c4_a;
  logic [63:0]                    c4_b;

  logic signed [cbe_pkg::S_W-1:0] c5_s;

  logic signed [cbe_pkg::S_W-1:0]  rnd;
  logic signed [cbe_pkg::YF_W-1:0] yf;

  assign v = cbe_pkg::U_W'(cbe_pkg::U_ONE) - in_u;

  // Advance valid and flag bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[3:0], in_valid};
      out_valid <= vld[4];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat <= {sat[3:0], in_sat};
    end
  end

  // Stage 1: u*v, u*u and the two control-y products
  always_ff @(posedge clk) begin
    if (en) begin
      c1_u  <= in_u;
      c1_uv <= 34'(in_u) * 34'(v);
      c1_uu <= 34'(in_u) * 34'(in_u);
      c1_vc <= $signed({1'b0, v}) * cfg.c1y;
      c1_uc <= $signed({1'b0, in_u}) * cfg.c2y;
    end
  end

  // Stage 2: w = v*c1y + u*c2y
  always_ff @(posedge clk) begin
    if (en) begin
      c2_u  <= c1_u;
      c2_uv <= c1_uv;
      c2_uu <= c1_uu;
      c2_w  <= 34'(c1_vc) + 34'(c1_uc);
    end
  end

  // Stage 3: u*v*w in two halves, and u^3
  always_ff @(posedge clk) begin
    if (en) begin
      c3_plo <= 50'(c2_uv) * 50'(c2_w[15:0]);
      c3_phi <= $signed({1'b0, c2_uv}) * $signed(c2_w[33:16]);
      c3_u3  <= 51'(c2_uu) * 51'(c2_u);
    end
  end

  // Stage 4: join the halves, scale u^3
  always_ff @(posedge clk) begin
    if (en) begin
      c4_a <= (cbe_pkg::S_W'(c3_phi) <<< 16) + cbe_pkg::S_W'(c3_plo);
      c4_b <= {c3_u3[50:0], 13'd0};
    end
  end

  // Stage 5: s = 3*u*v*w + 8192*u^3
  always_ff @(posedge clk) begin
    if (en) begin
      c5_s <= c4_a + (c4_a <<< 1) + cbe_pkg::S_W'(c4_b);
    end
  end

  // Stage 6: round half up to Q2.13 and saturate
  assign rnd = c5_s + (cbe_pkg::S_W'(1) <<< 47);
  assign yf  = rnd[cbe_pkg::S_W-1:48];

  always_ff @(posedge clk) begin
    if (en) begin
      if (yf > cbe_pkg::YF_W'(cbe_pkg::EASED_MAX)) begin
        out_eased <= cbe_pkg::EASED_W'(cbe_pkg::EASED_MAX);
        out_sat   <= 1'b1;
      end else if (yf < cbe_pkg::YF_W'(cbe_pkg::EASED_MIN)) begin
        out_eased <= cbe_pkg::EASED_W'(cbe_pkg::EASED_MIN);
        out_sat   <= 1'b1;
      end else begin
        out_eased <= yf[cbe_pkg::EASED_W-1:0];
        out_sat   <= sat[4];
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/cubic_bezier_easing_eval_top.sv
// ----------------------------------------------------------------------------
// cubic_bezier_easing_eval_top
// Cubic Bezier easing curve evaluator, streaming in and out.
// ----------------------------------------------------------------------------
// Takes one progress beat per clock while the skid entry is empty and returns
// one eased value per beat, in order. The unrolled pipeline has two stages for
// each of the six binary-search steps over the 64 curve samples, three stages
// that form the bracketing samples and set up the division, nine stages of the
// interpolation divider (two quotient bits each), one stage that clamps the
// parameter, six stages of the cubic and the output register. One skid entry
// behind the output register lets a new beat enter while a finished result
// waits; the pipeline holds only while that skid entry is full. The user writes
// control points through cfg_we/cfg_index/cfg_data only while no beat is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_easing_eval_top (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_we,
  input  wire [cbe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [15:0]                        cfg_data,
  input  wire                               s_tvalid,
  output logic                              s_tready,
  input  wire [15:0]                        s_tdata,   // [15:0] progress
  output logic                              m_tvalid,
  input  wire                               m_tready,
  output logic [15:0]                       m_tdata,   // [14:0] eased_value, [15] zero
  output logic                              m_tuser    // [0] saturated
);

  cbe_pkg::cfg_t   cfg;
  logic            en;

  logic            sv_valid [cbe_pkg::SEARCH_STEPS+1];
  cbe_pkg::srch_t  sv_srch  [cbe_pkg::SEARCH_STEPS+1];

  logic                         e1_valid;
  logic [cbe_pkg::IDX_W-1:0]    e1_l;
  logic [15:0]                  e1_prog;
  logic [cbe_pkg::P_W-1:0]      e1_pl1;
  logic [cbe_pkg::P_W-1:0]      e1_pl2;
  logic [cbe_pkg::K3_W-1:0]     e1_kl3;
  logic [cbe_pkg::P_W-1:0]      e1_pr1;
  logic [cbe_pkg::P_W-1:0]      e1_pr2;
  logic [cbe_pkg::K3_W-1:0]     e1_kr3;

  logic [cbe_pkg::SUM_W-1:0]    xl_sum;
  logic [cbe_pkg::SUM_W-1:0]    xr_sum;
  logic                         e2_valid;
  logic [cbe_pkg::IDX_W-1:0]    e2_l;
  logic [15:0]                  e2_prog;
  logic [cbe_pkg::X_W-1:0]      e2_xl;
  logic [cbe_pkg::X_W-1:0]      e2_xr;

  logic signed [cbe_pkg::D_W-1:0] d;
  logic [15:0]                    off;
  logic [cbe_pkg::R_W-1:0]        dividend;
  cbe_pkg::div_t                  div0;

  logic            dv_valid [cbe_pkg::DIV_STEPS+1];
  cbe_pkg::div_t   dv_div   [cbe_pkg::DIV_STEPS+1];

  cbe_pkg::div_t                 dq;
  logic [cbe_pkg::U_W+1:0]       base;
  logic [cbe_pkg::U_W+1:0]       u_sum;
  logic                          f_valid;
  logic [cbe_pkg::U_W-1:0]       f_u;
  logic                          f_sat;

  logic                                c_valid;
  logic signed [cbe_pkg::EASED_W-1:0]  c_eased;
  logic                                c_sat;

  logic                                skid_valid;
  logic signed [cbe_pkg::EASED_W-1:0]  skid_eased;
  logic                                skid_sat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.c1x <= 16'd8192;
      cfg.c1y <= 15'sd819;
      cfg.c2x <= 16'd8192;
      cfg.c2y <= 15'sd8192;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cbe_pkg::REG_CTRL1_X: cfg.c1x <= cfg_data;
        cbe_pkg::REG_CTRL1_Y: cfg.c1y <= cfg_data[14:0];
        cbe_pkg::REG_CTRL2_X: cfg.c2x <= cfg_data;
        cbe_pkg::REG_CTRL2_Y: cfg.c2y <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Whole pipeline advances unless the skid entry is occupied
  assign en       = !skid_valid;
  assign s_tready = en;

  // Binary search over the samples
  assign sv_valid[0]     = s_tvalid;
  assign sv_srch[0].l    = '0;
  assign sv_srch[0].r    = cbe_pkg::IDX_W'(cbe_pkg::SAMPLE_POINTS - 1);
  assign sv_srch[0].prog = s_tdata;

  for (genvar g = 0; g < cbe_pkg::SEARCH_STEPS; g++) begin : g_search
    cbe_search_step u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .cfg       (cfg),
      .in_valid  (sv_valid[g]),
      .in_srch   (sv_srch[g]),
      .out_valid (sv_valid[g+1]),
      .out_srch  (sv_srch[g+1])
    );
  end

  // Weigh the bracketing samples
  always_ff @(posedge clk) begin
    if (rst) begin
      e1_valid <= 1'b0;
      e2_valid <= 1'b0;
      dv_valid[0] <= 1'b0;
    end else if (en) begin
      e1_valid <= sv_valid[cbe_pkg::SEARCH_STEPS];
      e2_valid <= e1_valid;
      dv_valid[0] <= e2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_l    <= sv_srch[cbe_pkg::SEARCH_STEPS].l;
      e1_prog <= sv_srch[cbe_pkg::SEARCH_STEPS].prog;
      e1_pl1  <= cbe_pkg::P_W'(cbe_pkg::coef1(sv_srch[cbe_pkg::SEARCH_STEPS].l))
                 * cbe_pkg::P_W'(cfg.c1x);
      e1_pl2  <= cbe_pkg::P_W'(cbe_pkg::coef2(sv_srch[cbe_pkg::SEARCH_STEPS].l))
                 * cbe_pkg::P_W'(cfg.c2x);
      e1_kl3  <= cbe_pkg::coef3(sv_srch[cbe_pkg::SEARCH_STEPS].l);
      e1_pr1  <= cbe_pkg::P_W'(cbe_pkg::coef1(sv_srch[cbe_pkg::SEARCH_STEPS].r))
                 * cbe_pkg::P_W'(cfg.c1x);
      e1_pr2  <= cbe_pkg::P_W'(cbe_pkg::coef2(sv_srch[cbe_pkg::SEARCH_STEPS].r))
                 * cbe_pkg::P_W'(cfg.c2x);
      e1_kr3  <= cbe_pkg::coef3(sv_srch[cbe_pkg::SEARCH_STEPS].r);
    end
  end

  // Form x_left and x_right
  assign xl_sum = cbe_pkg::SUM_W'(e1_pl1) + cbe_pkg::SUM_W'(e1_pl2)
                + cbe_pkg::SUM_W'(e1_kl3);
  assign xr_sum = cbe_pkg::SUM_W'(e1_pr1) + cbe_pkg::SUM_W'(e1_pr2)
                + cbe_pkg::SUM_W'(e1_kr3);

  always_ff @(posedge clk) begin
    if (en) begin
      e2_l    <= e1_l;
      e2_prog <= e1_prog;
      e2_xl   <= xl_sum[cbe_pkg::SUM_W-1:cbe_pkg::N3_SHIFT];
      e2_xr   <= xr_sum[cbe_pkg::SUM_W-1:cbe_pkg::N3_SHIFT];
    end
  end

  // Set up the division (progress - x_left) * 2^FRAC_SHIFT / d
  assign d        = $signed({1'b0, e2_xr}) - $signed({1'b0, e2_xl});
  assign off      = e2_prog - e2_xl[15:0];
  assign dividend = {off, {cbe_pkg::FRAC_SHIFT{1'b0}}};

  always_comb begin
    div0.left = e2_l;
    div0.pos  = !d[cbe_pkg::D_W-1] && (d != '0);
    div0.d    = d[cbe_pkg::X_W-1:0];
    div0.rem  = cbe_pkg::D_W'(dividend[cbe_pkg::R_W-1:cbe_pkg::Q_W]);
    div0.ovf  = cbe_pkg::D_W'(dividend[cbe_pkg::R_W-1:cbe_pkg::Q_W])
                >= cbe_pkg::D_W'(d[cbe_pkg::X_W-1:0]);
    div0.low  = dividend[cbe_pkg::Q_W-1:0];
    div0.q    = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_div[0] <= div0;
    end
  end

  for (genvar g = 0; g < cbe_pkg::DIV_STEPS; g++) begin : g_div
    cbe_div_step u_div (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (dv_valid[g]),
      .in_div    (dv_div[g]),
      .out_valid (dv_valid[g+1]),
      .out_div   (dv_div[g+1])
    );
  end

  // Add the segment base and clamp u to one
  assign dq    = dv_div[cbe_pkg::DIV_STEPS];
  assign base  = (cbe_pkg::U_W+2)'(dq.left) << cbe_pkg::FRAC_SHIFT;
  assign u_sum = base + (cbe_pkg::U_W+2)'(dq.q);

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= dv_valid[cbe_pkg::DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!dq.pos) begin
        f_u   <= base[cbe_pkg::U_W-1:0];
        f_sat <= 1'b0;
      end else if (dq.ovf || (u_sum > (cbe_pkg::U_W+2)'(cbe_pkg::U_ONE))) begin
        f_u   <= cbe_pkg::U_W'(cbe_pkg::U_ONE);
        f_sat <= 1'b1;
      end else begin
        f_u   <= u_sum[cbe_pkg::U_W-1:0];
        f_sat <= 1'b0;
      end
    end
  end

  cbe_cubic u_cubic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (f_valid),
    .in_u      (f_u),
    .in_sat    (f_sat),
    .out_valid (c_valid),
    .out_eased (c_eased),
    .out_sat   (c_sat)
  );

  // Output register with one skid entry; the skid entry is only ever full
  // while the output register holds a beat
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid   <= skid_valid || (en && c_valid);
        skid_valid <= 1'b0;
      end else if (!m_tvalid) begin
        m_tvalid   <= en && c_valid;
      end else if (en && c_valid) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (m_tvalid && m_tready && skid_valid) begin
      m_tdata <= {1'b0, skid_eased};
      m_tuser <= skid_sat;
    end else if (en && c_valid && (!m_tvalid || m_tready)) begin
      m_tdata <= {1'b0, c_eased};
      m_tuser <= c_sat;
    end
    if (en && c_valid && m_tvalid && !m_tready) begin
      skid_eased <= c_eased;
      skid_sat   <= c_sat;
    end
  end

endmodule

`default_nettype wire
